/* rtl/core/w1d_pkg.sv */
// Shared types, constants and status codes of the one-dimensional earth mover's distance block.
// It has no dependencies.
package w1d_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int POS_BITS   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int TW = 16 + CW;
    localparam int NW = 64 + 2 * TW + FRAC_BITS;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;

    typedef struct packed {
        logic [15:0]         wt;
        logic [POS_BITS-1:0] pos;
    } t_point;
endpackage

/* rtl/core/wasserstein_1d_distance.sv */
// Top level of the one-dimensional weighted earth mover's distance block.
// It depends on w1d_pkg and w1d_divider.
//
// Channel  Direction  Handshake           Fields
// input    in         start / busy        i_set_select, i_position, i_weight, i_last
// result   out        o_valid strobe      o_distance, o_status
//
// A point that is not last is stored in its set's memory while room is left. A
// last transaction first sums the weights of both sets, then sorts both sets in
// their memories by insertion sort, then merges them and divides.
// Reset is synchronous and clears counts and control; memories are not cleared.
// The receiver cannot stall: the result strobe is high for exactly one cycle.
module wasserstein_1d_distance import w1d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_set_select,
    input  logic [15:0] i_position,
    input  logic [15:0] i_weight,
    input  logic        i_last,
    output logic        o_valid,
    output logic [31:0] o_distance,
    output logic [1:0]  o_status
);
    localparam logic [3:0] S_LOAD = 4'd0, S_SI = 4'd1, S_SKR = 4'd2, S_SKW = 4'd3,
        S_SCR = 4'd4, S_SCW = 4'd5, S_SPUT = 4'd6, S_MRD = 4'd7, S_MGO = 4'd8,
        S_DIV = 4'd9, S_WAIT = 4'd10, S_OUT = 4'd11, S_TOT = 4'd12, S_TOTW = 4'd13;

    t_point r_mem_a [MAX_POINTS];
    t_point r_mem_b [MAX_POINTS];
    t_point r_rd_a, r_rd_b;
    logic [AW-1:0] w_ra, w_rb, w_wa;
    logic w_we_a, w_we_b;
    t_point w_wd;

    logic [3:0] r_st;
    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic r_ovf;
    logic r_sel;
    logic [CW-1:0] r_i, r_j, r_k;
    t_point r_key;
    logic [TW-1:0] r_tot_a, r_tot_b, r_cum_a, r_cum_b;
    logic [NW-1:0] r_sum;
    logic [POS_BITS-1:0] r_x;
    logic r_have_x;
    logic [2*TW-1:0] r_pa, r_pb;
    logic [POS_BITS-1:0] r_gap;
    logic [2*TW-1:0] r_dd;
    logic [1:0] r_status;
    logic r_div_go;
    logic w_div_done;
    logic [31:0] w_quot;
    logic [2*TW-1:0] w_den;

    logic [CW-1:0] w_n;
    t_point w_rd;
    assign w_n  = r_sel ? r_cnt_b : r_cnt_a;
    assign w_rd = r_sel ? r_rd_b : r_rd_a;

    always_comb begin
        w_ra = r_k[AW-1:0];
        w_rb = r_k[AW-1:0];
        w_wa = r_k[AW-1:0];
        w_we_a = 1'b0;
        w_we_b = 1'b0;
        w_wd = r_key;
        if (r_st == S_MRD || r_st == S_MGO) begin
            w_ra = r_i[AW-1:0];
            w_rb = r_j[AW-1:0];
        end
        case (r_st)
            S_LOAD: begin
                w_wa = i_set_select ? r_cnt_b[AW-1:0] : r_cnt_a[AW-1:0];
                w_wd = '{wt: i_weight, pos: i_position[POS_BITS-1:0]};
                w_we_a = start && !i_set_select && r_cnt_a != CW'(MAX_POINTS);
                w_we_b = start && i_set_select && r_cnt_b != CW'(MAX_POINTS);
            end
            S_SCW: begin
                w_wa = r_k[AW-1:0];
                w_wd = w_rd;
                w_we_a = !r_sel && w_rd.pos > r_key.pos;
                w_we_b = r_sel && w_rd.pos > r_key.pos;
                w_wa = r_k[AW-1:0] + 1'b1;
            end
            S_SPUT: begin
                w_wa = r_k[AW-1:0];
                w_we_a = !r_sel;
                w_we_b = r_sel;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_a) r_mem_a[w_wa] <= w_wd;
        if (w_we_b) r_mem_b[w_wa] <= w_wd;
        r_rd_a <= r_mem_a[w_ra];
        r_rd_b <= r_mem_b[w_rb];
    end

    logic w_ha, w_hb, w_take_a, w_take_b;
    logic [POS_BITS-1:0] w_min;
    assign w_ha = r_i < r_cnt_a;
    assign w_hb = r_j < r_cnt_b;
    assign w_min = (w_ha && (!w_hb || r_rd_a.pos <= r_rd_b.pos)) ? r_rd_a.pos : r_rd_b.pos;
    assign w_take_a = w_ha && r_rd_a.pos == w_min;
    assign w_take_b = !w_take_a && w_hb && r_rd_b.pos == w_min;

    logic [2*TW-1:0] w_d;
    logic [POS_BITS+2*TW-1:0] w_area;
    assign w_d = r_pa > r_pb ? r_pa - r_pb : r_pb - r_pa;
    assign w_area = r_gap * r_dd;
    assign w_den = r_tot_a * r_tot_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf <= 1'b0;
            r_div_go <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            o_valid <= 1'b0;
            case (r_st)
                S_LOAD: if (start) begin
                    if (w_we_a) r_cnt_a <= r_cnt_a + 1'b1;
                    if (w_we_b) r_cnt_b <= r_cnt_b + 1'b1;
                    if ((!i_set_select && r_cnt_a == CW'(MAX_POINTS)) ||
                        (i_set_select && r_cnt_b == CW'(MAX_POINTS)) || r_ovf) begin
                        if (i_last) begin
                            r_status <= ST_OVFL;
                            o_distance <= '0;
                            r_st <= S_OUT;
                        end else r_ovf <= 1'b1;
                    end else if (i_last) begin
                        r_sel <= 1'b0;
                        r_k <= '0;
                        r_tot_a <= '0;
                        r_tot_b <= '0;
                        r_st <= S_TOT;
                    end
                end
                S_TOT: begin
                    r_st <= S_TOTW;
                end
                S_TOTW: begin
                    if (r_k < w_n) begin
                        if (r_sel) r_tot_b <= r_tot_b + TW'(w_rd.wt);
                        else r_tot_a <= r_tot_a + TW'(w_rd.wt);
                    end
                    if (r_k + 1'b1 < w_n) begin
                        r_k <= r_k + 1'b1;
                        r_st <= S_TOT;
                    end else if (!r_sel) begin
                        r_sel <= 1'b1;
                        r_k <= '0;
                        r_st <= S_TOT;
                    end else begin
                        r_sel <= 1'b0;
                        r_i <= CW'(1);
                        r_st <= S_SI;
                    end
                end
                S_SI: begin
                    if (r_tot_a == '0 || r_tot_b == '0) begin
                        r_status <= ST_EMPTY;
                        o_distance <= '0;
                        r_st <= S_OUT;
                    end else if (r_i >= w_n) begin
                        if (!r_sel) begin
                            r_sel <= 1'b1;
                            r_i <= CW'(1);
                        end else begin
                            r_i <= '0;
                            r_j <= '0;
                            r_cum_a <= '0;
                            r_cum_b <= '0;
                            r_sum <= '0;
                            r_have_x <= 1'b0;
                            r_pa <= '0;
                            r_pb <= '0;
                            r_gap <= '0;
                            r_dd <= '0;
                            r_st <= S_MRD;
                        end
                    end else begin
                        r_k <= r_i;
                        r_st <= S_SKR;
                    end
                end
                S_SKR: r_st <= S_SKW;
                S_SKW: begin
                    r_key <= w_rd;
                    r_k <= r_i;
                    if (r_i == '0) r_st <= S_SPUT;
                    else begin
                        r_k <= r_i - 1'b1;
                        r_st <= S_SCR;
                    end
                end
                S_SCR: r_st <= S_SCW;
                S_SCW: begin
                    if (w_rd.pos > r_key.pos) begin
                        if (r_k == '0) r_st <= S_SPUT;
                        else begin
                            r_k <= r_k - 1'b1;
                            r_st <= S_SCR;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_st <= S_SPUT;
                    end
                end
                S_SPUT: begin
                    r_i <= r_i + 1'b1;
                    r_st <= S_SI;
                end
                S_MRD: begin
                    r_pa <= r_cum_a * r_tot_b;
                    r_pb <= r_cum_b * r_tot_a;
                    r_sum <= r_sum + NW'(w_area);
                    r_gap <= '0;
                    r_st <= S_MGO;
                end
                S_MGO: begin
                    if (!w_ha && !w_hb) begin
                        r_div_go <= 1'b1;
                        r_st <= S_DIV;
                    end else begin
                        if (r_have_x && w_min != r_x) begin
                            r_gap <= w_min - r_x;
                            r_dd <= w_d;
                        end
                        r_x <= w_min;
                        r_have_x <= 1'b1;
                        if (w_take_a) begin
                            r_cum_a <= r_cum_a + TW'(r_rd_a.wt);
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_cum_b <= r_cum_b + TW'(r_rd_b.wt);
                            r_j <= r_j + 1'b1;
                        end
                        r_st <= S_MRD;
                    end
                end
                S_DIV: r_st <= S_WAIT;
                S_WAIT: if (w_div_done) begin
                    o_distance <= w_quot;
                    r_status <= ST_OK;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_cnt_a <= '0;
                    r_cnt_b <= '0;
                    r_ovf <= 1'b0;
                    r_st <= S_LOAD;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    w1d_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_div_go),
        .i_num  (r_sum << FRAC_BITS),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign busy = r_st != S_LOAD;
    assign o_status = r_status;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("block busy after a result");
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_a <= CW'(MAX_POINTS) && r_cnt_b <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_distance == '0)
        else $error("nonzero distance with error status");
endmodule

/* rtl/core/w1d_divider.sv */
// Restoring divider for the final scaled sum, one quotient bit per cycle.
// It depends on w1d_pkg.
module w1d_divider import w1d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [NW-1:0]     i_num,
    input  logic [2*TW-1:0]   i_den,
    output logic              o_done,
    output logic [31:0]       o_quot
);
    localparam int SW = $clog2(NW + 1);
    logic [NW-1:0]   r_num;
    logic [2*TW:0]   r_rem;
    logic [NW-1:0]   r_q;
    logic [2*TW-1:0] r_den;
    logic [SW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [2*TW:0]   w_sh;
    logic            w_ge;

    assign w_sh = {r_rem[2*TW-1:0], r_num[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q   <= {r_q[NW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_q[NW-1:32]) ? 32'hFFFF_FFFF : r_q[31:0];
endmodule
